@@ hw/rtl/kres_pkg.sv @@
// Package for the keypad release scanner: types, sizes and the fixed key map.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package kres_pkg;

  // Size of the digit entry store and derived widths
  localparam int ENTRY_DEPTH = 16;
  localparam int CNT_W       = $clog2(ENTRY_DEPTH + 1);
  localparam int ADDR_W      = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

  // Key matrix and field widths
  localparam int NUM_KEYS    = 16;
  localparam int POS_W       = 4;
  localparam int DIGIT_W     = 4;
  localparam int COUNT_OUT_W = 5;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 20;
  localparam int OUT_TDATA_W = 24;

  // Bit positions inside out_tdata
  localparam int OB_FOUND = 0;
  localparam int OB_POS   = 1;
  localparam int OB_CLASS = 5;
  localparam int OB_DIGIT = 8;
  localparam int OB_WROTE = 12;
  localparam int OB_COUNT = 13;
  localparam int OB_SEND  = 18;
  localparam int OB_STOP  = 19;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_DIGIT  = 3'd1,
    CLS_SEND   = 3'd2,
    CLS_END    = 3'd3,
    CLS_UNUSED = 3'd4
  } key_class_t;

  // Release search result for one sample
  typedef struct packed {
    logic                   found;
    logic [POS_W-1:0]       pos;
    key_class_t             cls;
    logic [DIGIT_W-1:0]     dig;
    logic [NUM_KEYS-1:0]    last_nxt;
  } scan_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic                   stopped;
    logic                   send_ready;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   digit_written;
    logic [DIGIT_W-1:0]     digit_value;
    key_class_t             key_class;
    logic [POS_W-1:0]       key_position;
    logic                   key_found;
  } result_t;

  // Key map, position = col*4+row
  function automatic key_class_t key_class_of(input logic [POS_W-1:0] pos);
    key_class_t c;
    case (pos)
      4'd0:                               c = CLS_SEND;
      4'd12:                              c = CLS_END;
      4'd2, 4'd3, 4'd4, 4'd8:             c = CLS_UNUSED;
      default:                            c = CLS_DIGIT;
    endcase
    return c;
  endfunction

  function automatic logic [DIGIT_W-1:0] key_digit_of(input logic [POS_W-1:0] pos);
    logic [DIGIT_W-1:0] d;
    case (pos)
      4'd5:    d = 4'd9;
      4'd6:    d = 4'd6;
      4'd7:    d = 4'd3;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd5;
      4'd11:   d = 4'd2;
      4'd13:   d = 4'd7;
      4'd14:   d = 4'd4;
      4'd15:   d = 4'd1;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/kres_scan.sv @@
// Release detector: finds the lowest released key position and classifies it.
// Depends on kres_pkg. Purely combinational.
`timescale 1ns / 1ps

module kres_scan (
  input  logic [kres_pkg::NUM_KEYS-1:0] prev,
  input  logic [kres_pkg::NUM_KEYS-1:0] cur,
  output kres_pkg::scan_t               scan
);
  import kres_pkg::*;

  logic [NUM_KEYS-1:0] rel;
  logic [NUM_KEYS-1:0] lowmask;
  logic [NUM_KEYS-1:0] first_hot;
  logic [POS_W-1:0]    pos;

  // Lowest set bit of rel and the mask of all bits up to and including it.
  // With no release the mask is all ones, so the whole sample is taken.
  assign rel       = prev & ~cur;
  assign lowmask   = rel ^ (rel - NUM_KEYS'(1));
  assign first_hot = rel & lowmask;

  // One-hot to binary
  always_comb begin
    pos = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (first_hot[i]) pos = pos | POS_W'(i);
    end
  end

  always_comb begin
    scan.found    = |rel;
    scan.pos      = scan.found ? pos : '0;
    scan.cls      = scan.found ? key_class_of(pos) : CLS_NONE;
    scan.dig      = (scan.found && key_class_of(pos) == CLS_DIGIT) ? key_digit_of(pos) : '0;
    scan.last_nxt = (cur & lowmask) | (prev & ~lowmask);
  end

endmodule

@@ hw/rtl/kres_entry.sv @@
// Entry state: remembered key sample, digit store, count, send and stop flags.
// Depends on kres_pkg and kres_scan.
`timescale 1ns / 1ps

module kres_entry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,   // one item processed this cycle
  input  logic                          mode,
  input  logic [kres_pkg::NUM_KEYS-1:0] sample,
  output kres_pkg::result_t             res
);
  import kres_pkg::*;

  logic [NUM_KEYS-1:0]  last_r, last_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 send_r, send_nxt;
  logic                 stop_r, stop_nxt;
  logic                 wr_en;
  logic [DIGIT_W-1:0]   store_mem [ENTRY_DEPTH];
  logic                 full;
  logic                 active;
  scan_t                scan;

  kres_scan u_scan (
    .prev (last_r),
    .cur  (sample),
    .scan (scan)
  );

  assign full   = (count_r >= CNT_W'(ENTRY_DEPTH));
  assign active = !mode && !stop_r;

  // Next state
  always_comb begin
    last_nxt  = last_r;
    count_nxt = count_r;
    send_nxt  = send_r;
    stop_nxt  = stop_r;
    wr_en     = 1'b0;
    if (mode) begin
      count_nxt = '0;
      send_nxt  = 1'b0;
    end else if (!stop_r) begin
      last_nxt = scan.last_nxt;
      if (scan.found) begin
        if (scan.cls == CLS_SEND || full) begin
          send_nxt = 1'b1;
        end else if (scan.cls == CLS_DIGIT) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else if (scan.cls == CLS_END) begin
          stop_nxt = 1'b1;
        end
      end
    end
  end

  // Result item
  always_comb begin
    res.key_found     = active && scan.found;
    res.key_position  = active ? scan.pos : '0;
    res.key_class     = active ? scan.cls : CLS_NONE;
    res.digit_value   = active ? scan.dig : '0;
    res.digit_written = wr_en;
    res.entry_count   = COUNT_OUT_W'(count_nxt);
    res.send_ready    = send_nxt;
    res.stopped       = stop_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      count_r <= '0;
      send_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else if (step) begin
      last_r  <= last_nxt;
      count_r <= count_nxt;
      send_r  <= send_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Digit store, kept for the dial-out side; appended at the fill count
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store_mem[count_r[ADDR_W-1:0]] <= scan.dig;
    end
  end

endmodule

@@ hw/rtl/keypad_release_scan_digit_entry_top.sv @@
// Keypad release scanner with digit entry buffer, top level.
//
// Input channel (in_*): one transfer per 4x4 matrix snapshot. in_tdata holds
// the pressed mask (bit col*4+row set = pressed); in_tuser selects the item
// kind: 0 = scan sample, 1 = clear the entry buffer and the send flag.
// Output channel (out_*): exactly one result per input transfer, in order,
// carrying the detected release, its class and digit, the entry count and
// the sticky send and stop flags.
// Path: a result passes the input register, then the state update into the
// result register, where it stays until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall; the
// release search is a single lowest-bit priority pick over the 16-bit
// sample, settled combinationally.
// Reset (rst_n low, synchronous): both stage registers empty, remembered
// sample all released, entry count zero, send and stop flags clear.
// Receiver stall: the result register holds; the input register still takes
// one more item, after which in_tready drops until out_tready returns.
`timescale 1ns / 1ps

module keypad_release_scan_digit_entry_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kres_pkg::IN_TDATA_W-1:0]  in_tdata,  // [15:0] pressed_mask
  input  logic                             in_tuser,  // [0] mode
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] key_found, [4:1] key_position, [7:5] key_class, [11:8] digit_value,
  // [12] digit_written, [17:13] entry_count, [18] send_ready, [19] stopped,
  // [23:20] zero
  output logic [kres_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kres_pkg::*;

  logic                  in_valid_r;
  logic                  in_mode_r;
  logic [NUM_KEYS-1:0]   in_mask_r;
  logic                  out_valid_r;
  result_t               out_res_r;
  result_t               res;
  logic                  step;

  // Item moves from the input register into the result register
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  kres_entry u_entry (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .mode   (in_mode_r),
    .sample (in_mask_r),
    .res    (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_mask_r <= in_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_res_r};

endmodule

@@ hw/rtl/kres_chk.sv @@
// Port-level checker for the keypad release scanner, bound to the top level.
// Depends on kres_pkg.
`timescale 1ns / 1ps

module kres_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [kres_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kres_pkg::*;

  // No result survives reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Without a release all key fields are zero
  a_no_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OB_FOUND] |-> out_tdata[OB_WROTE:OB_POS] == '0)
    else $error("key fields set without a release");

  // A stored digit comes only from a released digit key
  a_write_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_WROTE] |->
      out_tdata[OB_FOUND] && out_tdata[OB_DIGIT-1:OB_CLASS] == CLS_DIGIT)
    else $error("digit written for a non-digit key");

  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OB_SEND-1:OB_COUNT] <= COUNT_OUT_W'(ENTRY_DEPTH))
    else $error("entry count beyond store depth");

endmodule

bind keypad_release_scan_digit_entry_top kres_chk u_kres_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
